[rtl/core/qvr_pkg.sv]
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int QUAT_WIDTH     = 16;
  localparam int VEC_WIDTH      = 16;
  localparam int QUAT_FRAC_BITS = 14;

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] quat_r;
    logic signed [QUAT_WIDTH-1:0] quat_i;
    logic signed [QUAT_WIDTH-1:0] quat_j;
    logic signed [QUAT_WIDTH-1:0] quat_k;
    logic signed [VEC_WIDTH-1:0]  vec_x;
    logic signed [VEC_WIDTH-1:0]  vec_y;
    logic signed [VEC_WIDTH-1:0]  vec_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] rot_x;
    logic signed [VEC_WIDTH-1:0] rot_y;
    logic signed [VEC_WIDTH-1:0] rot_z;
    logic                        saturated;
  } qvr_out_t;

endpackage

[rtl/core/quaternion_vector_rotate.sv]
`timescale 1ns / 1ps

// register stages, in order from the accepting edge: products, first sums,
//   second products, rounded sums, clip
// throughput: one item per cycle while no result waits under out_stall_i, every stage
// moves on together; the whole pipeline holds while a result waits under out_stall_i
// reset clears the stage valid bits only, data registers are not reset

module quaternion_vector_rotate #(
  parameter int QuatFracBits = qvr_pkg::QUAT_FRAC_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  qvr_pkg::qvr_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output qvr_pkg::qvr_out_t out_data_o
);

  localparam int QW    = qvr_pkg::QUAT_WIDTH;
  localparam int VW    = qvr_pkg::VEC_WIDTH;
  localparam int P1W   = QW + VW;
  localparam int TW    = QW + VW + 1;
  localparam int P2W   = TW + QW;
  localparam int SW    = P2W + 1;
  localparam int Shift = 2 * QuatFracBits;
  localparam int RW    = (SW + 1 > Shift + 2) ? SW + 1 : Shift + 2;

  localparam logic signed [RW-1:0] RoundHalf = RW'(1) << (Shift - 1);
  localparam logic signed [RW-1:0] MaxVal = {{(RW-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [RW-1:0] MinVal = {{(RW-VW+1){1'b1}}, {(VW-1){1'b0}}};

  logic advance;
  logic v1_q, v2_q, v3_q, v4_q, out_valid_q;

  assign advance     = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !advance;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  // stage 1: q times v, twelve products
  logic signed [P1W-1:0] rx_q, ry_q, rz_q, ix_q, iy_q, iz_q;
  logic signed [P1W-1:0] jx_q, jy_q, jz_q, kx_q, ky_q, kz_q;
  logic signed [QW-1:0]  qr1_q, qi1_q, qj1_q, qk1_q;

  // stage 2: t = q * (0, v)
  logic signed [TW-1:0] tr_q, ti_q, tj_q, tk_q;
  logic signed [QW-1:0] qr2_q, qi2_q, qj2_q, qk2_q;

  // stage 3: t times q, twelve products
  logic signed [P2W-1:0] m_ri_q, m_rj_q, m_rk_q;
  logic signed [P2W-1:0] m_ir_q, m_ij_q, m_ik_q;
  logic signed [P2W-1:0] m_jr_q, m_ji_q, m_jk_q;
  logic signed [P2W-1:0] m_kr_q, m_ki_q, m_kj_q;

  // stage 4: vector part of t * conj(q), plus one half for rounding
  logic signed [RW-1:0] sx_q, sy_q, sz_q;

  // stage 5: shift, clip
  logic signed [RW-1:0] shx, shy, shz;
  logic                 satx, saty, satz;
  qvr_pkg::qvr_out_t    out_d, out_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rx_q  <= in_data_i.quat_r * in_data_i.vec_x;
      ry_q  <= in_data_i.quat_r * in_data_i.vec_y;
      rz_q  <= in_data_i.quat_r * in_data_i.vec_z;
      ix_q  <= in_data_i.quat_i * in_data_i.vec_x;
      iy_q  <= in_data_i.quat_i * in_data_i.vec_y;
      iz_q  <= in_data_i.quat_i * in_data_i.vec_z;
      jx_q  <= in_data_i.quat_j * in_data_i.vec_x;
      jy_q  <= in_data_i.quat_j * in_data_i.vec_y;
      jz_q  <= in_data_i.quat_j * in_data_i.vec_z;
      kx_q  <= in_data_i.quat_k * in_data_i.vec_x;
      ky_q  <= in_data_i.quat_k * in_data_i.vec_y;
      kz_q  <= in_data_i.quat_k * in_data_i.vec_z;
      qr1_q <= in_data_i.quat_r;
      qi1_q <= in_data_i.quat_i;
      qj1_q <= in_data_i.quat_j;
      qk1_q <= in_data_i.quat_k;

      ti_q  <= TW'(rx_q) + TW'(jz_q) - TW'(ky_q);
      tj_q  <= TW'(ry_q) - TW'(iz_q) + TW'(kx_q);
      tk_q  <= TW'(rz_q) + TW'(iy_q) - TW'(jx_q);
      tr_q  <= -TW'(ix_q) - TW'(jy_q) - TW'(kz_q);
      qr2_q <= qr1_q;
      qi2_q <= qi1_q;
      qj2_q <= qj1_q;
      qk2_q <= qk1_q;

      m_ri_q <= tr_q * qi2_q;
      m_rj_q <= tr_q * qj2_q;
      m_rk_q <= tr_q * qk2_q;
      m_ir_q <= ti_q * qr2_q;
      m_ij_q <= ti_q * qj2_q;
      m_ik_q <= ti_q * qk2_q;
      m_jr_q <= tj_q * qr2_q;
      m_ji_q <= tj_q * qi2_q;
      m_jk_q <= tj_q * qk2_q;
      m_kr_q <= tk_q * qr2_q;
      m_ki_q <= tk_q * qi2_q;
      m_kj_q <= tk_q * qj2_q;

      // conj(q) folded into the signs
      sx_q <= RW'(m_ir_q) - RW'(m_ri_q) - RW'(m_jk_q) + RW'(m_kj_q) + RoundHalf;
      sy_q <= RW'(m_jr_q) - RW'(m_rj_q) + RW'(m_ik_q) - RW'(m_ki_q) + RoundHalf;
      sz_q <= RW'(m_kr_q) - RW'(m_rk_q) - RW'(m_ij_q) + RW'(m_ji_q) + RoundHalf;

      out_q <= out_d;
    end
  end

  always_comb begin
    shx = sx_q >>> Shift;
    shy = sy_q >>> Shift;
    shz = sz_q >>> Shift;
    satx = (shx > MaxVal) || (shx < MinVal);
    saty = (shy > MaxVal) || (shy < MinVal);
    satz = (shz > MaxVal) || (shz < MinVal);

    if (shx > MaxVal)      out_d.rot_x = MaxVal[VW-1:0];
    else if (shx < MinVal) out_d.rot_x = MinVal[VW-1:0];
    else                   out_d.rot_x = shx[VW-1:0];

    if (shy > MaxVal)      out_d.rot_y = MaxVal[VW-1:0];
    else if (shy < MinVal) out_d.rot_y = MinVal[VW-1:0];
    else                   out_d.rot_y = shy[VW-1:0];

    if (shz > MaxVal)      out_d.rot_z = MaxVal[VW-1:0];
    else if (shz < MinVal) out_d.rot_z = MinVal[VW-1:0];
    else                   out_d.rot_z = shz[VW-1:0];

    out_d.saturated = satx || saty || satz;
  end

  assign out_data_o = out_q;

endmodule

[rtl/core/qvr_checker.sv]
`timescale 1ns / 1ps

module qvr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input qvr_pkg::qvr_out_t out_data_o
);

  localparam int VW = qvr_pkg::VEC_WIDTH;
  localparam logic signed [VW-1:0] VecMax = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VecMin = {1'b1, {(VW-1){1'b0}}};

  logic in_accept;
  assign in_accept = in_valid_i && !in_stall_o;

  // a waiting result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // input side holds back only behind a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a waiting result");

  // an accepted item reaches the output when out_stall_i stays low along the way
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("item lost in the pipeline");

  // a saturated result has at least one component on a bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      (out_data_o.rot_x == VecMax) || (out_data_o.rot_x == VecMin) ||
      (out_data_o.rot_y == VecMax) || (out_data_o.rot_y == VecMin) ||
      (out_data_o.rot_z == VecMax) || (out_data_o.rot_z == VecMin))
    else $error("saturation flagged with no component on a bound");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

[tb/sv/tb_quaternion_vector_rotate.sv]
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_stall;
  qvr_pkg::qvr_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  qvr_pkg::qvr_out_t out_data;

  qvr_pkg::qvr_out_t rot_expected[$];
  int       error_count;
  int       gap_pct;
  int       stall_pct;
  int       hold_reqs;
  int       hold_seen;
  int       stall_left;

  quaternion_vector_rotate u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  // q * (0, v) * conj(q), exact, then divide by 2^(2*frac) with round half up and clip
  function automatic qvr_pkg::qvr_out_t rotate_vector(qvr_pkg::qvr_in_t item);
    longint qr, qi, qj, qk, x, y, z;
    longint ti, tj, tk, tr, rnd, vmax, vmin;
    longint acc[3];
    logic signed [qvr_pkg::VEC_WIDTH-1:0] comp[3];
    qvr_pkg::qvr_out_t res;
    qr = longint'(item.quat_r);
    qi = longint'(item.quat_i);
    qj = longint'(item.quat_j);
    qk = longint'(item.quat_k);
    x  = longint'(item.vec_x);
    y  = longint'(item.vec_y);
    z  = longint'(item.vec_z);
    ti = qr * x + qj * z - qk * y;
    tj = qr * y - qi * z + qk * x;
    tk = qr * z + qi * y - qj * x;
    tr = -(qi * x) - qj * y - qk * z;
    acc[0] = tr * (-qi) + ti * qr + tj * (-qk) - tk * (-qj);
    acc[1] = tr * (-qj) - ti * (-qk) + tj * qr + tk * (-qi);
    acc[2] = tr * (-qk) + ti * (-qj) - tj * (-qi) + tk * qr;
    vmax = (longint'(1) <<< (qvr_pkg::VEC_WIDTH - 1)) - 1;
    vmin = -vmax - 1;
    res.saturated = 1'b0;
    for (int n = 0; n < 3; n++) begin
      rnd = (acc[n] + (longint'(1) <<< (2 * qvr_pkg::QUAT_FRAC_BITS - 1)))
            >>> (2 * qvr_pkg::QUAT_FRAC_BITS);
      if (rnd > vmax) begin
        rnd = vmax;
        res.saturated = 1'b1;
      end else if (rnd < vmin) begin
        rnd = vmin;
        res.saturated = 1'b1;
      end
      comp[n] = rnd[qvr_pkg::VEC_WIDTH-1:0];
    end
    res.rot_x = comp[0];
    res.rot_y = comp[1];
    res.rot_z = comp[2];
    return res;
  endfunction

  function automatic qvr_pkg::qvr_in_t make_item(int r, int i, int j, int k,
                                                 int x, int y, int z);
    qvr_pkg::qvr_in_t item;
    item.quat_r = r[qvr_pkg::QUAT_WIDTH-1:0];
    item.quat_i = i[qvr_pkg::QUAT_WIDTH-1:0];
    item.quat_j = j[qvr_pkg::QUAT_WIDTH-1:0];
    item.quat_k = k[qvr_pkg::QUAT_WIDTH-1:0];
    item.vec_x  = x[qvr_pkg::VEC_WIDTH-1:0];
    item.vec_y  = y[qvr_pkg::VEC_WIDTH-1:0];
    item.vec_z  = z[qvr_pkg::VEC_WIDTH-1:0];
    return item;
  endfunction

  // any bit pattern across the whole item
  function automatic qvr_pkg::qvr_in_t rand_item();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(qvr_pkg::qvr_in_t)-1:0];
  endfunction

  // optional idle gap, then hold the item until the block takes it
  task automatic send_item(qvr_pkg::qvr_in_t item);
    int gap;
    gap = 0;
    if ($urandom_range(99) < gap_pct) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(40, 5) : $urandom_range(3, 1);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    rot_expected.push_back(rotate_vector(item));
  endtask

  // result checker and stall generator
  always @(posedge clk_i) begin
    qvr_pkg::qvr_out_t want;
    if (!rst_ni) begin
      error_count = 0;
      out_stall  <= 1'b0;
      stall_left <= 0;
      hold_seen  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rot_expected.size() == 0) begin
          $error("unexpected item: rot_x %0d rot_y %0d rot_z %0d sat %0b",
                 out_data.rot_x, out_data.rot_y, out_data.rot_z, out_data.saturated);
          error_count++;
        end else begin
          want = rot_expected.pop_front();
          if (out_data.rot_x !== want.rot_x) begin
            $error("rot_x expected %0d actual %0d", want.rot_x, out_data.rot_x);
            error_count++;
          end
          if (out_data.rot_y !== want.rot_y) begin
            $error("rot_y expected %0d actual %0d", want.rot_y, out_data.rot_y);
            error_count++;
          end
          if (out_data.rot_z !== want.rot_z) begin
            $error("rot_z expected %0d actual %0d", want.rot_z, out_data.rot_z);
            error_count++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated expected %0b actual %0b", want.saturated,
                   out_data.saturated);
            error_count++;
          end
        end
      end
      if (hold_reqs != hold_seen) begin
        // long hold-off so the pipeline fills and stalls its input
        hold_seen  <= hold_reqs;
        stall_left <= 80;
        out_stall  <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else begin
        out_stall  <= ($urandom_range(99) < stall_pct);
        stall_left <= ($urandom_range(9) == 0) ? $urandom_range(30, 5) : $urandom_range(2);
      end
    end
  end

  task automatic test_directed();
    gap_pct = 30;
    stall_pct <= 30;
    send_item(make_item(16384, 0, 0, 0, 32767, -32768, 0));
    send_item(make_item(16384, 0, 0, 0, -1, 1, 32767));
    send_item(make_item(11585, 0, 0, 11585, 10000, 0, 0));
    send_item(make_item(11585, 11585, 0, 0, 0, 10000, -5000));
    send_item(make_item(11585, 0, 11585, 0, 1234, -4321, 777));
    send_item(make_item(0, 16384, 0, 0, 100, 200, 300));
    send_item(make_item(0, 0, 0, 0, 32767, -32768, 32767));
    send_item(make_item(-32768, -32768, -32768, -32768, 32767, 32767, 32767));
    send_item(make_item(-32768, 0, 0, 0, -32768, -32768, 32767));
    send_item(make_item(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_item(make_item(0, 0, 0, -32768, -32768, 32767, -1));
    // non-unit quaternion scales the vector
    send_item(make_item(32767, 0, 0, 0, 100, -100, 1));
    send_item(make_item(23170, 0, 0, 0, 5000, -7000, 9000));
    // exact halves round toward plus infinity
    send_item(make_item(8192, 0, 0, 0, 2, -2, -6));
    send_item(make_item(8192, 0, 0, 0, 6, -10, 2));
    send_item(make_item(1, 1, 1, 1, 1, 1, 1));
    send_item(make_item(-1, -1, -1, -1, -32768, -32768, -32768));
  endtask

  task automatic test_random_full(int count);
    gap_pct = 40;
    stall_pct <= 40;
    for (int n = 0; n < count; n++) begin
      send_item(rand_item());
    end
  endtask

  // quaternions in the usual range around unit length
  task automatic test_random_rotation(int count);
    int lim;
    gap_pct = 25;
    stall_pct <= 25;
    for (int n = 0; n < count; n++) begin
      lim = ($urandom_range(3) == 0) ? 16384 : 11585;
      send_item(make_item($urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                          $urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                          $urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                          $urandom_range(65535) - 32768));
    end
  endtask

  task automatic test_backpressure(int count);
    gap_pct = 0;
    stall_pct <= 0;
    hold_reqs <= hold_reqs + 1;
    for (int n = 0; n < count; n++) begin
      send_item(rand_item());
    end
  endtask

  task automatic test_streaming(int count);
    gap_pct = 0;
    stall_pct <= 0;
    for (int n = 0; n < count; n++) begin
      send_item(rand_item());
    end
  endtask

  initial begin
    int waited;
    gap_pct     = 0;
    rst_ni     <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    stall_pct  <= 0;
    hold_reqs  <= 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_full(300);
    test_backpressure(40);
    test_random_rotation(300);
    test_streaming(100);
    test_backpressure(40);
    test_random_full(40);

    in_valid  <= 1'b0;
    stall_pct <= 0;
    waited = 0;
    while (rot_expected.size() != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (20) @(posedge clk_i);
    if (rot_expected.size() != 0) begin
      $error("%0d expected items never arrived", rot_expected.size());
    end
    if (error_count == 0 && rot_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
